// File: sv/chvh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chvh_pkg;

   localparam logic [31:0] K_V0 = 32'hdeadbeef;
   localparam logic [31:0] K_V2 = 32'hb19dea15;
   localparam logic [31:0] M_A  = 32'hb8b34b2d;
   localparam logic [31:0] M_B  = 32'h52c6a2d9;
   localparam logic [31:0] M_C  = 32'hcc9e2d51;
   localparam logic [31:0] M_D  = 32'hc6a4a793;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] BLOCK_BYTES = 4'd8;

   // one classified item as the back end consumes it
   typedef struct packed {
      logic [31:0] w1_xor;
      logic [31:0] w3_xor;
      logic        w2_xor;
      logic [3:0]  count_add;
      logic        fin;
   } chvh_entry_type;

   typedef struct packed {
      logic                   valid;
      logic [QUEUE_CNT_W-1:0] count;
      chvh_entry_type         entry;
   } chvh_queue_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

   // mask of the low n bytes of a word
   function automatic logic [31:0] low_mask(input logic [2:0] n);
      case (n)
         3'd0:    low_mask = 32'h00000000;
         3'd1:    low_mask = 32'h000000ff;
         3'd2:    low_mask = 32'h0000ffff;
         3'd3:    low_mask = 32'h00ffffff;
         default: low_mask = 32'hffffffff;
      endcase
   endfunction

endpackage

`default_nettype wire

// File: sv/chaskey_variant_hash32_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_data_lo, req_data_hi, req_tail_bytes, req_final_item
// rsp      out  rsp_valid/rsp_stall  rsp_tag
// csr      in   csr_valid/csr_ready  csr_seed
//
// a full block goes through the back end as load, then two half rounds
// a final item goes through load, two half rounds, two multiply steps, then tag load
// the front queue holds 2 items, so req_stall rises only when both are waiting
// the tag sits in an output register; the back end holds at tag load while it is stalled
// reset is synchronous; seed resets to zero, csr_ready is always high

module chaskey_variant_hash32_core
   import chvh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_data_lo,
   input  wire logic [31:0] req_data_hi,
   input  wire logic [2:0]  req_tail_bytes,
   input  wire logic        req_final_item,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_tag,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_seed
);

   logic [31:0]    seed_ff;
   chvh_queue_type q_link;
   logic           q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'h0;
      end else if (csr_valid && csr_ready) begin
         seed_ff <= csr_seed;
      end
   end

   chvh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_lo    (req_data_lo),
      .req_data_hi    (req_data_hi),
      .req_tail_bytes (req_tail_bytes),
      .req_final_item (req_final_item),
      .q_pop          (q_pop),
      .q_link         (q_link)
   );

   chvh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .q_link    (q_link),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_tag   (rsp_tag)
   );

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_link.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_link.valid)
      else $error("stall with empty queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_link.valid)
      else $error("pop from empty queue");

   a_reset_rsp: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// File: sv/chvh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module chvh_front
   import chvh_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [31:0]    req_data_lo,
   input  wire logic [31:0]    req_data_hi,
   input  wire logic [2:0]     req_tail_bytes,
   input  wire logic           req_final_item,
   input  wire logic           q_pop,
   output chvh_queue_type      q_link
);

   chvh_entry_type         q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   chvh_entry_type         new_entry;
   logic [31:0]            mask_lo;
   logic [31:0]            mask_hi;
   logic                   push;
   logic                   pop;

   // classify: full block or tail item with masked bytes
   always_comb begin
      mask_lo = low_mask(req_tail_bytes);
      mask_hi = (req_tail_bytes > 3'd4) ? low_mask(req_tail_bytes - 3'd4) : 32'h0;
      if (req_final_item) begin
         new_entry.w1_xor    = req_data_hi & mask_hi;
         new_entry.w3_xor    = req_data_lo & mask_lo;
         new_entry.w2_xor    = 1'b0;
         new_entry.count_add = {1'b0, req_tail_bytes};
         new_entry.fin       = 1'b1;
      end else begin
         new_entry.w1_xor    = req_data_lo;
         new_entry.w3_xor    = req_data_hi;
         new_entry.w2_xor    = 1'b1;
         new_entry.count_add = BLOCK_BYTES;
         new_entry.fin       = 1'b0;
      end
   end

   assign req_stall = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign q_link.valid = (count_ff != '0);
   assign q_link.count = count_ff;
   assign q_link.entry = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: sv/chvh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module chvh_back
   import chvh_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [31:0]    seed,
   input  wire chvh_queue_type q_link,
   output logic                q_pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [31:0]         rsp_tag
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HALF1,
      ST_HALF2,
      ST_MUL1,
      ST_MUL2,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] w_ff [4];
   logic [31:0] w_in [4];
   logic [15:0] cnt_ff, cnt_in;
   logic        inmsg_ff, inmsg_in;
   logic        fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_tag_ff, rsp_tag_in;

   logic [31:0] base [4];
   logic [15:0] base_cnt;
   logic [15:0] new_cnt;
   logic [31:0] sum_a;
   logic [31:0] sum_c;
   logic [31:0] tag_val;
   logic        load_tag;

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      cnt_in       = cnt_ff;
      inmsg_in     = inmsg_ff;
      fin_in       = fin_ff;
      rsp_tag_in   = rsp_tag_ff;
      q_pop        = 1'b0;
      load_tag     = 1'b0;
      sum_a        = 32'h0;
      sum_c        = 32'h0;
      tag_val      = w_ff[0] ^ rotl32(w_ff[1], 8) ^ rotl32(w_ff[2], 16)
                     ^ rotl32(w_ff[3], 24);
      // reseed at message start
      if (inmsg_ff) begin
         base     = w_ff;
         base_cnt = cnt_ff;
      end else begin
         base[0]  = seed ^ K_V0;
         base[1]  = seed;
         base[2]  = seed ^ K_V2;
         base[3]  = seed;
         base_cnt = 16'h0;
      end
      new_cnt = base_cnt + {12'h0, q_link.entry.count_add};

      case (state_ff)
         ST_IDLE: begin
            if (q_link.valid) begin
               q_pop    = 1'b1;
               w_in[0]  = q_link.entry.fin ? (base[0] ^ {new_cnt, 16'h0}) : base[0];
               w_in[1]  = base[1] ^ q_link.entry.w1_xor;
               w_in[2]  = base[2] ^ {31'h0, q_link.entry.w2_xor};
               w_in[3]  = base[3] ^ q_link.entry.w3_xor;
               cnt_in   = new_cnt;
               fin_in   = q_link.entry.fin;
               inmsg_in = !q_link.entry.fin;
               state_in = ST_HALF1;
            end
         end
         ST_HALF1: begin
            sum_a    = w_ff[0] + w_ff[1];
            sum_c    = w_ff[2] + w_ff[3];
            w_in[0]  = rotl32(sum_a, 16);
            w_in[1]  = rotl32(w_ff[1], 5) ^ sum_a;
            w_in[2]  = sum_c;
            w_in[3]  = rotl32(w_ff[3], 8) ^ sum_c;
            state_in = ST_HALF2;
         end
         ST_HALF2: begin
            sum_a    = w_ff[2] + w_ff[1];
            sum_c    = w_ff[0] + w_ff[3];
            w_in[2]  = rotl32(sum_a, 16);
            w_in[1]  = rotl32(w_ff[1], 7) ^ sum_a;
            w_in[0]  = sum_c;
            w_in[3]  = rotl32(w_ff[3], 13) ^ sum_c;
            state_in = fin_ff ? ST_MUL1 : ST_IDLE;
         end
         ST_MUL1: begin
            w_in[0]  = w_ff[0] * M_B;
            w_in[1]  = w_ff[1] * M_C;
            w_in[2]  = w_ff[2] * M_D;
            w_in[3]  = w_ff[3] * M_A;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            w_in[0]  = (w_ff[0] ^ (w_ff[0] >> 16)) * M_C;
            w_in[1]  = (w_ff[1] ^ (w_ff[1] >> 16)) * M_D;
            w_in[2]  = (w_ff[2] ^ (w_ff[2] >> 16)) * M_A;
            w_in[3]  = (w_ff[3] ^ (w_ff[3] >> 16)) * M_B;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_tag   = 1'b1;
               rsp_tag_in = tag_val;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_tag) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inmsg_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inmsg_ff     <= inmsg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff       <= w_in;
      cnt_ff     <= cnt_in;
      fin_ff     <= fin_in;
      rsp_tag_ff <= rsp_tag_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tag   = rsp_tag_ff;

endmodule

`default_nettype wire

// File: tb/chaskey_variant_hash32_core_tb.sv
`timescale 1ns / 1ps

module chaskey_variant_hash32_core_tb;
   import chvh_pkg::*;

   typedef logic [3:0][31:0] mix_state_type;

   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_lo = '0;
   logic [31:0] req_data_hi = '0;
   logic [2:0]  req_tail_bytes = '0;
   logic        req_final_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_tag;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_seed = '0;

   logic [31:0]   tag_queue[$];
   logic [31:0]   seed_copy = '0;
   mix_state_type mix_copy = '0;
   logic [15:0]   byte_total = '0;
   logic          message_open = 1'b0;
   logic          no_idle = 1'b0;
   int            mismatches = 0;
   int            items_sent = 0;
   int            cycle_count = 0;

   chaskey_variant_hash32_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_lo    (req_data_lo),
      .req_data_hi    (req_data_hi),
      .req_tail_bytes (req_tail_bytes),
      .req_final_item (req_final_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tag        (rsp_tag),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 24);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tag_queue.size() == 0) begin
            $error("tag: unexpected item, actual %h", rsp_tag);
            mismatches++;
         end else begin
            if (rsp_tag !== tag_queue[0]) begin
               $error("tag mismatch: expected %h actual %h", tag_queue[0], rsp_tag);
               mismatches++;
            end
            void'(tag_queue.pop_front());
         end
      end
   end

   function automatic logic [31:0] rol(input logic [31:0] x, input int r);
      logic [63:0] wide;
      wide = {x, x} << r;
      return wide[63:32];
   endfunction

   function automatic logic [31:0] byte_mask(input logic [2:0] n);
      if (n >= 3'd4) return 32'hffffffff;
      return (32'h1 << (8 * n)) - 32'h1;
   endfunction

   function automatic mix_state_type permute(input mix_state_type w);
      logic [31:0] a, b, c, d;
      a = w[0];
      b = w[1];
      c = w[2];
      d = w[3];
      a = a + b;
      c = c + d;
      b = rol(b, 5) ^ a;
      d = rol(d, 8) ^ c;
      a = rol(a, 16);
      c = c + b;
      a = a + d;
      b = rol(b, 7) ^ c;
      d = rol(d, 13) ^ a;
      c = rol(c, 16);
      return {d, c, b, a};
   endfunction

   function automatic logic [31:0] fold_tag(input mix_state_type w);
      logic [31:0] v0, v1, v2, v3;
      v0 = w[0] * M_B;
      v1 = w[1] * M_C;
      v2 = w[2] * M_D;
      v3 = w[3] * M_A;
      v0 = v0 ^ (v0 >> 16);
      v1 = v1 ^ (v1 >> 16);
      v2 = v2 ^ (v2 >> 16);
      v3 = v3 ^ (v3 >> 16);
      v0 = v0 * M_C;
      v1 = v1 * M_D;
      v2 = v2 * M_A;
      v3 = v3 * M_B;
      return v0 ^ rol(v1, 8) ^ rol(v2, 16) ^ rol(v3, 24);
   endfunction

   task automatic absorb_item(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [2:0] tail, input logic fin);
      if (!message_open) begin
         mix_copy   = {seed_copy, seed_copy ^ K_V2, seed_copy, seed_copy ^ K_V0};
         byte_total = '0;
      end
      if (!fin) begin
         mix_copy[1] = mix_copy[1] ^ lo;
         mix_copy[3] = mix_copy[3] ^ hi;
         mix_copy[2] = mix_copy[2] ^ 32'h1;
         mix_copy    = permute(mix_copy);
         byte_total  = byte_total + 16'd8;
         message_open = 1'b1;
      end else begin
         byte_total  = byte_total + 16'(tail);
         mix_copy[3] = mix_copy[3] ^ (lo & byte_mask(tail));
         if (tail > 3'd4) mix_copy[1] = mix_copy[1] ^ (hi & byte_mask(tail - 3'd4));
         mix_copy[0] = mix_copy[0] ^ {byte_total, 16'h0000};
         mix_copy    = permute(mix_copy);
         tag_queue.push_back(fold_tag(mix_copy));
         message_open = 1'b0;
      end
   endtask

   function automatic logic [31:0] pick_word();
      int sel;
      sel = $urandom_range(19);
      if (sel == 0) return 32'h00000000;
      if (sel == 1) return 32'hffffffff;
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_seed();
      int sel;
      sel = $urandom_range(5);
      if (sel == 0) return 32'h00000000;
      if (sel == 1) return 32'hffffffff;
      return $urandom;
   endfunction

   task automatic send_item(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [2:0] tail, input logic fin);
      @(negedge clock);
      if (!no_idle) begin
         while ($urandom_range(99) < 24) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_data_lo    <= lo;
      req_data_hi    <= hi;
      req_tail_bytes <= tail;
      req_final_item <= fin;
      do @(posedge clock); while (req_stall);
      absorb_item(lo, hi, tail, fin);
      items_sent++;
   endtask

   task automatic send_message(input int blocks, input logic [2:0] tail);
      for (int i = 0; i < blocks; i++) send_item(pick_word(), pick_word(), 3'($urandom), 1'b0);
      send_item(pick_word(), pick_word(), tail, 1'b1);
   endtask

   // let the core finish everything in flight, including blocks with no tag
   task automatic drain_core();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tag_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock); while (!csr_ready);
      seed_copy = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_seed();
      send_item(32'hffffffff, 32'hffffffff, 3'd0, 1'b1);
      send_item(32'h00000000, 32'h00000000, 3'd0, 1'b0);
      send_item(32'h00000000, 32'h00000000, 3'd0, 1'b1);
      send_item(32'hffffffff, 32'hffffffff, 3'd7, 1'b0);
      send_item(32'hffffffff, 32'hffffffff, 3'd7, 1'b1);
      drain_core();
   endtask

   task automatic test_tail_lengths();
      write_seed(32'hffffffff);
      for (int n = 0; n < 8; n++) send_item(32'hffffffff, 32'hffffffff, 3'(n), 1'b1);
      send_item(32'h00000000, 32'h00000000, 3'd3, 1'b0);
      send_item(32'h00000000, 32'h00000000, 3'd7, 1'b1);
      send_item(32'h12345678, 32'h9abcdef0, 3'd4, 1'b1);
      send_item(32'h12345678, 32'h9abcdef0, 3'd5, 1'b1);
      drain_core();
   endtask

   // new seed must only apply from the next message on
   task automatic test_seed_mid_message();
      send_item(32'ha5a5a5a5, 32'h5a5a5a5a, 3'd1, 1'b0);
      send_item(32'h0f0f0f0f, 32'hf0f0f0f0, 3'd6, 1'b0);
      drain_core();
      write_seed(32'h00000000);
      send_item(32'h01234567, 32'h89abcdef, 3'd6, 1'b1);
      send_item(32'h01234567, 32'h89abcdef, 3'd6, 1'b1);
      drain_core();
   endtask

   // long unbroken message, byte count well past eight bits
   task automatic test_long_message();
      write_seed($urandom);
      no_idle = 1'b1;
      send_message(150, 3'd5);
      no_idle = 1'b0;
      drain_core();
   endtask

   task automatic test_random(input int count);
      int goal;
      int blocks;
      goal = items_sent + count;
      while (items_sent < goal) begin
         if ($urandom_range(19) == 0) begin
            drain_core();
            write_seed(pick_seed());
         end
         blocks = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(6);
         if ($urandom_range(29) == 0) begin
            for (int i = 0; i <= blocks; i++)
               send_item(pick_word(), pick_word(), 3'($urandom), 1'b0);
            drain_core();
            write_seed(pick_seed());
            send_item(pick_word(), pick_word(), 3'($urandom_range(7)), 1'b1);
         end else begin
            send_message(blocks, 3'($urandom_range(7)));
         end
      end
      drain_core();
   endtask

   task automatic test_back_to_back(input int count);
      int goal;
      goal = items_sent + count;
      no_idle = 1'b1;
      while (items_sent < goal) send_message($urandom_range(4), 3'($urandom_range(7)));
      no_idle = 1'b0;
      drain_core();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_seed();
      test_tail_lengths();
      test_seed_mid_message();
      test_long_message();
      test_random(950);
      test_back_to_back(130);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tag_queue.size() != 0) begin
         $error("tag: %0d items never arrived", tag_queue.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/chvh_pkg.sv
sv/chvh_front.sv
sv/chvh_back.sv
sv/chaskey_variant_hash32_core.sv
tb/chaskey_variant_hash32_core_tb.sv
